// ----- hw/rtl/mi3_pkg.sv -----
// Shared constants, types and index tables for the 3x3 matrix inverse.
package mi3_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int StoreDepth = 9;
   localparam int AddrWidth  = 4;

   // controller states, one-hot
   typedef enum logic [10:0] {
      S_LOAD   = 11'b00000000001,
      S_FETCH  = 11'b00000000010,
      S_MSTART = 11'b00000000100,
      S_MUL    = 11'b00000001000,
      S_ACC    = 11'b00000010000,
      S_CHECK  = 11'b00000100000,
      S_DFETCH = 11'b00001000000,
      S_DSTART = 11'b00010000000,
      S_DIV    = 11'b00100000000,
      S_EMIT   = 11'b01000000000,
      S_SEMIT  = 11'b10000000000
   } state_type;

   // command bundle, controller to datapath
   typedef struct packed {
      logic                 mat_we;
      logic [AddrWidth-1:0] mat_waddr;
      logic [AddrWidth-1:0] addr_a;
      logic [AddrWidth-1:0] addr_b;
      logic [AddrWidth-1:0] cof_addr;
      logic                 cof_we;
      logic                 mul_start;
      logic                 mul_det;
      logic                 mul_step;
      logic                 acc_en;
      logic                 acc_odd;
      logic                 acc_det;
      logic                 acc_first;
      logic                 div_start;
      logic                 div_step;
      logic                 emit;
      logic                 emit_sing;
      logic [AddrWidth-1:0] emit_pos;
      logic                 emit_last;
   } cmd_type;

   // status bundle, datapath to controller
   typedef struct packed {
      logic det_zero;
      logic out_busy;
   } status_type;

   // operand indexes of each cofactor: a*b - c*d
   function automatic logic [15:0] adj_row(input logic [AddrWidth-1:0] k);
      logic [15:0] row;
      case (k)
         4'd0:    row = {4'd4, 4'd8, 4'd5, 4'd7};
         4'd1:    row = {4'd2, 4'd7, 4'd1, 4'd8};
         4'd2:    row = {4'd1, 4'd5, 4'd2, 4'd4};
         4'd3:    row = {4'd5, 4'd6, 4'd3, 4'd8};
         4'd4:    row = {4'd0, 4'd8, 4'd2, 4'd6};
         4'd5:    row = {4'd2, 4'd3, 4'd0, 4'd5};
         4'd6:    row = {4'd3, 4'd7, 4'd4, 4'd6};
         4'd7:    row = {4'd1, 4'd6, 4'd0, 4'd7};
         4'd8:    row = {4'd0, 4'd4, 4'd1, 4'd3};
         default: row = '0;
      endcase
      return row;
   endfunction

   // cofactor that pairs with first-row entry j in the determinant
   function automatic logic [AddrWidth-1:0] det_cof(input logic [1:0] j);
      logic [AddrWidth-1:0] a;
      case (j)
         2'd0:    a = 4'd0;
         2'd1:    a = 4'd3;
         2'd2:    a = 4'd6;
         default: a = 4'd0;
      endcase
      return a;
   endfunction

endpackage

// ----- hw/rtl/matrix_inverse_3x3.sv -----
// Top level of the 3x3 signed fixed-point matrix inverse.
//
// Input channel req_: one beat per matrix entry, row-major, nine beats a
// matrix; the block takes one entry per cycle while loading.
// After the ninth beat req_stall stays high while the block works: the
// cofactors and the determinant take 21 products on one shift-add
// multiplier; each of the nine quotients then comes from one restoring
// divider and is handed to the result register as a result beat.
// Result channel rsp_: nine beats in row-major order with entry_position
// and last on the ninth, or one beat with singular and last set when the
// determinant is zero. Quotients round toward zero and saturate.
// The result register parts the two sides: while the last beat waits the
// next matrix loads. A stalled receiver holds the sequencer before the
// next result beat; nothing is dropped.
// Reset clears the sequencer, the load count and the result valid.
module matrix_inverse_3x3 #(
   parameter int DATA_WIDTH = mi3_pkg::DataWidth,
   parameter int FRAC_BITS  = mi3_pkg::FracBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_entry_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_inverse_value,
   output logic [3:0]                   rsp_entry_position,
   output logic                         rsp_singular,
   output logic                         rsp_last
);
   import mi3_pkg::*;

   cmd_type    cmd;
   status_type status;

   mi3_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .status(status), .cmd(cmd)
   );

   mi3_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_entry_value(req_entry_value), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_inverse_value(rsp_inverse_value),
      .rsp_entry_position(rsp_entry_position), .rsp_singular(rsp_singular),
      .rsp_last(rsp_last)
   );

   // a singular beat is the only beat of its matrix
   a_sing_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last && rsp_entry_position == 4'd0
         && rsp_inverse_value == '0)
      else $error("singular beat malformed");

   // the last regular beat carries the final position
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_singular |-> rsp_entry_position == 4'd8)
      else $error("last beat at wrong position");

   // no new entry is taken while a result is being computed
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step || cmd.mul_step |-> req_stall)
      else $error("entry accepted during computation");

endmodule

// ----- hw/rtl/mi3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mi3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/mi3_ctrl.sv -----
// Sequencer: load, cofactor/determinant products, divisions, result beats.
module mi3_ctrl #(
   parameter int DATA_WIDTH = mi3_pkg::DataWidth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mi3_pkg::status_type status,
   output mi3_pkg::cmd_type    cmd
);
   import mi3_pkg::*;

   localparam int CntW = $clog2(DATA_WIDTH);
   localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);
   localparam logic [4:0] OpDet   = 5'd18;
   localparam logic [4:0] OpFinal = 5'd20;

   state_type            state_ff, state_in;
   logic [AddrWidth-1:0] load_ff, load_in;
   logic [4:0]           op_ff, op_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [AddrWidth-1:0] idx_ff, idx_in;

   logic [15:0]          row;
   logic [4:0]           jop;
   logic                 is_det;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         load_ff  <= '0;
         op_ff    <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   // operand addresses follow the product index
   assign row    = adj_row(op_ff[4:1]);
   assign jop    = op_ff - OpDet;
   assign is_det = (op_ff >= OpDet);

   always_comb begin
      state_in  = state_ff;
      load_in   = load_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      req_stall = 1'b1;
      cmd       = '0;

      cmd.mat_waddr = load_ff;
      cmd.mul_det   = is_det;
      cmd.acc_odd   = op_ff[0];
      cmd.acc_det   = is_det;
      cmd.acc_first = (op_ff == OpDet);
      cmd.emit_pos  = idx_ff;
      if (is_det) begin
         cmd.addr_a   = {2'b00, jop[1:0]};
         cmd.addr_b   = {2'b00, jop[1:0]};
         cmd.cof_addr = det_cof(jop[1:0]);
      end else begin
         cmd.addr_a   = op_ff[0] ? row[3:0] : row[11:8];
         cmd.addr_b   = op_ff[0] ? row[7:4] : row[15:12];
         cmd.cof_addr = op_ff[4:1];
      end

      case (state_ff)
         S_LOAD: begin
            req_stall  = 1'b0;
            cmd.mat_we = req_valid;
            if (req_valid) begin
               if (load_ff == AddrWidth'(StoreDepth - 1)) begin
                  load_in  = '0;
                  op_in    = '0;
                  state_in = S_FETCH;
               end else begin
                  load_in = load_ff + 1'b1;
               end
            end
         end
         S_FETCH: begin
            state_in = S_MSTART;
         end
         S_MSTART: begin
            cmd.mul_start = 1'b1;
            cnt_in        = '0;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            cmd.cof_we = !is_det && op_ff[0];
            op_in      = op_ff + 1'b1;
            state_in   = (op_ff == OpFinal) ? S_CHECK : S_FETCH;
         end
         S_CHECK: begin
            idx_in   = '0;
            state_in = status.det_zero ? S_SEMIT : S_DFETCH;
         end
         S_DFETCH: begin
            cmd.cof_addr = idx_ff;
            state_in     = S_DSTART;
         end
         S_DSTART: begin
            cmd.cof_addr  = idx_ff;
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (idx_ff == AddrWidth'(StoreDepth - 1));
               if (cmd.emit_last) begin
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_DFETCH;
               end
            end
         end
         S_SEMIT: begin
            cmd.emit_pos = '0;
            if (!status.out_busy) begin
               cmd.emit      = 1'b1;
               cmd.emit_sing = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

// ----- hw/rtl/mi3_dp.sv -----
// Datapath: entry store, serial multiplier, cofactor store, restoring divider, output register.
module mi3_dp #(
   parameter int DATA_WIDTH = mi3_pkg::DataWidth,
   parameter int FRAC_BITS  = mi3_pkg::FracBits
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mi3_pkg::cmd_type            cmd,
   output mi3_pkg::status_type         status,
   input  logic signed [DATA_WIDTH-1:0] req_entry_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_inverse_value,
   output logic [3:0]                  rsp_entry_position,
   output logic                        rsp_singular,
   output logic                        rsp_last
);
   import mi3_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = 2 * W + 2;              // cofactor
   localparam int PW = 3 * W + 4;              // products and determinant
   localparam int DW = 4 * W + 2 * FRAC_BITS + 4; // divider

   logic signed [W-1:0]  ent_a, ent_b;
   logic signed [CW-1:0] cof_wdata, cof_rd;

   // matrix entries, one copy per read port
   mi3_ram #(.WIDTH(W), .DEPTH(StoreDepth)) u_mat_a (
      .clock(clock), .we(cmd.mat_we), .waddr(cmd.mat_waddr),
      .wdata(req_entry_value), .raddr(cmd.addr_a), .rdata(ent_a)
   );
   mi3_ram #(.WIDTH(W), .DEPTH(StoreDepth)) u_mat_b (
      .clock(clock), .we(cmd.mat_we), .waddr(cmd.mat_waddr),
      .wdata(req_entry_value), .raddr(cmd.addr_b), .rdata(ent_b)
   );
   mi3_ram #(.WIDTH(CW), .DEPTH(StoreDepth)) u_cof (
      .clock(clock), .we(cmd.cof_we), .waddr(cmd.cof_addr),
      .wdata(cof_wdata), .raddr(cmd.cof_addr), .rdata(cof_rd)
   );

   // shift-add multiplier over the magnitude of the entry operand
   logic signed [PW-1:0] acc_ff, acc_in, ash_ff, ash_in;
   logic [W-1:0]         bmag_ff, bmag_in;
   logic                 bneg_ff, bneg_in;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] temp_ff, det_ff;

   always_comb begin
      acc_in  = acc_ff;
      ash_in  = ash_ff;
      bmag_in = bmag_ff;
      bneg_in = bneg_ff;
      if (cmd.mul_start) begin
         acc_in  = '0;
         ash_in  = cmd.mul_det ? {{(PW-CW){cof_rd[CW-1]}}, cof_rd}
                               : {{(PW-W){ent_b[W-1]}}, ent_b};
         bneg_in = ent_a[W-1];
         bmag_in = ent_a[W-1] ? W'(-ent_a) : ent_a;
      end else if (cmd.mul_step) begin
         if (bmag_ff[0]) begin
            acc_in = acc_ff + ash_ff;
         end
         ash_in  = ash_ff <<< 1;
         bmag_in = bmag_ff >> 1;
      end
   end

   assign prod      = bneg_ff ? -acc_ff : acc_ff;
   assign cof_wdata = CW'(temp_ff - prod);

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      ash_ff  <= ash_in;
      bmag_ff <= bmag_in;
      bneg_ff <= bneg_in;
      if (cmd.acc_en) begin
         if (cmd.acc_det) begin
            det_ff <= cmd.acc_first ? prod : det_ff + prod;
         end else if (!cmd.acc_odd) begin
            temp_ff <= prod;
         end
      end
   end

   assign status.det_zero = (det_ff == '0);

   // restoring divider on magnitudes, W quotient bits plus an overflow test
   logic [CW-1:0]  cof_mag;
   logic [PW-1:0]  det_mag;
   logic [DW-1:0]  n_mag, d_mag;
   logic [DW-1:0]  rem_ff, dv_ff;
   logic [W-1:0]   q_ff;
   logic           big_ff, neg_ff;
   logic [W-1:0]   lim, sat;

   assign cof_mag = cof_rd[CW-1] ? CW'(-cof_rd) : cof_rd;
   assign det_mag = det_ff[PW-1] ? PW'(-det_ff) : det_ff;
   assign n_mag   = DW'(cof_mag) << (2 * FRAC_BITS);
   assign d_mag   = DW'(det_mag);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= n_mag;
         dv_ff  <= d_mag << (W - 1);
         q_ff   <= '0;
         big_ff <= (n_mag >= (d_mag << W));
         neg_ff <= cof_rd[CW-1] ^ det_ff[PW-1];
      end else if (cmd.div_step) begin
         if (rem_ff >= dv_ff) begin
            rem_ff <= rem_ff - dv_ff;
            q_ff   <= {q_ff[W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[W-2:0], 1'b0};
         end
         dv_ff <= dv_ff >> 1;
      end
   end

   // saturate the quotient to the signed output range
   assign lim = {1'b1, {(W-1){1'b0}}};
   always_comb begin
      if (neg_ff) begin
         sat = (big_ff || (q_ff > lim)) ? lim : W'(-q_ff);
      end else begin
         sat = (big_ff || q_ff[W-1]) ? ~lim : q_ff;
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_inverse_value  <= cmd.emit_sing ? '0 : sat;
         rsp_entry_position <= cmd.emit_pos;
         rsp_singular       <= cmd.emit_sing;
         rsp_last           <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

endmodule

// ----- verif/matrix_inverse_3x3_tb.sv -----
// Self-checking testbench for the 3x3 matrix inverse: random and directed matrices.
module matrix_inverse_3x3_tb;
   import mi3_pkg::*;

   localparam int W = DataWidth;
   localparam int CycleLimit = 3000000;
   localparam int DrainCycles = 1200;

   typedef logic signed [191:0] wide_type;

   // one expected result beat
   typedef struct {
      logic signed [W-1:0] inverse_value;
      logic [3:0]          entry_position;
      logic                singular;
      logic                last;
   } inverse_beat_type;

   // tracks loaded entries, predicts the inverse, checks result beats
   class inverse_scoreboard;
      logic signed [W-1:0] entries[9];
      int unsigned         loaded;
      inverse_beat_type    expected_beats[$];
      int unsigned         mismatches;

      // cofactor operand indexes: a*b - c*d
      int cof_ops[9][4] = '{
         '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
         '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
         '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

      function new();
         loaded = 0;
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // store an accepted entry; on the ninth, predict the whole result run
      function void note_entry(logic signed [W-1:0] value);
         wide_type         m[9];
         wide_type         cof[9];
         wide_type         det, quot;
         wide_type         hi_bound, lo_bound;
         inverse_beat_type b;
         entries[loaded] = value;
         loaded++;
         if (loaded < 9) return;
         loaded = 0;
         for (int k = 0; k < 9; k++) m[k] = entries[k];
         for (int k = 0; k < 9; k++)
            cof[k] = m[cof_ops[k][0]] * m[cof_ops[k][1]]
                   - m[cof_ops[k][2]] * m[cof_ops[k][3]];
         det = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
         if (det == 0) begin
            b.inverse_value = '0;
            b.entry_position = '0;
            b.singular = 1'b1;
            b.last = 1'b1;
            expected_beats.push_back(b);
            return;
         end
         hi_bound = (wide_type'(1) <<< (W - 1)) - 1;
         lo_bound = -(wide_type'(1) <<< (W - 1));
         for (int k = 0; k < 9; k++) begin
            // signed division truncates toward zero
            quot = (cof[k] <<< (2 * FracBits)) / det;
            if (quot > hi_bound) quot = hi_bound;
            if (quot < lo_bound) quot = lo_bound;
            b.inverse_value = quot[W-1:0];
            b.entry_position = 4'(k);
            b.singular = 1'b0;
            b.last = (k == 8);
            expected_beats.push_back(b);
         end
      endfunction

      task check_beat(inverse_beat_type got);
         inverse_beat_type e;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat value=%h pos=%0d",
                             got.inverse_value, got.entry_position));
            return;
         end
         e = expected_beats.pop_front();
         if (got.inverse_value !== e.inverse_value)
            report($sformatf("pos %0d value got %h exp %h", e.entry_position,
                             got.inverse_value, e.inverse_value));
         if (got.entry_position !== e.entry_position)
            report($sformatf("position got %0d exp %0d",
                             got.entry_position, e.entry_position));
         if (got.singular !== e.singular)
            report($sformatf("singular got %b exp %b", got.singular, e.singular));
         if (got.last !== e.last)
            report($sformatf("last got %b exp %b", got.last, e.last));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic signed [W-1:0] req_entry_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic signed [W-1:0] rsp_inverse_value;
   logic [3:0]          rsp_entry_position;
   logic                rsp_singular;
   logic                rsp_last;

   inverse_scoreboard sb = new();
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned cycle_count;

   matrix_inverse_3x3 u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_inverse_value  (rsp_inverse_value),
      .rsp_entry_position (rsp_entry_position),
      .rsp_singular       (rsp_singular),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stall at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // result beats are taken at the rising edge
   always @(posedge clock) begin
      inverse_beat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.inverse_value = rsp_inverse_value;
         got.entry_position = rsp_entry_position;
         got.singular = rsp_singular;
         got.last = rsp_last;
         sb.check_beat(got);
      end
   end

   // send one entry beat, idling at random first
   task automatic send_entry(logic signed [W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_entry_value <= value;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
         @(negedge clock);
      end
      sb.note_entry(value);
      @(negedge clock);
   endtask

   task automatic send_matrix(logic signed [W-1:0] m[9]);
      for (int k = 0; k < 9; k++) send_entry(m[k]);
   endtask

   // small Q16.16 value in about +-4.0
   function automatic logic signed [W-1:0] small_q();
      return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   // random matrix of a chosen flavor
   task automatic send_random_matrix();
      logic signed [W-1:0] m[9];
      int flavor;
      int r;
      flavor = $urandom_range(9);
      for (int k = 0; k < 9; k++) begin
         case (flavor)
            0, 1:    m[k] = $urandom();
            2, 3, 4: m[k] = small_q();
            5:       m[k] = $signed($urandom_range(16)) - 8;
            default: m[k] = small_q() >>> $urandom_range(12);
         endcase
      end
      // singular flavors: repeated row, zero column, or, on half of the draws, repeated column
      if (flavor == 7) begin
         r = $urandom_range(2);
         for (int c = 0; c < 3; c++) m[((r + 1) % 3) * 3 + c] = m[r * 3 + c];
      end else if (flavor == 8) begin
         r = $urandom_range(2);
         for (int row = 0; row < 3; row++) m[row * 3 + r] = '0;
      end else if (flavor == 9 && $urandom_range(1)) begin
         for (int row = 0; row < 3; row++) m[row * 3 + 2] = m[row * 3];
      end
      send_matrix(m);
   endtask

   task automatic directed_part();
      logic signed [W-1:0] m[9];
      // identity
      m = '{32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000};
      send_matrix(m);
      // all zero: singular
      m = '{default: '0};
      send_matrix(m);
      // tiny positive and negative diagonal: saturates both ways
      m = '{32'sd1, 0, 0, 0, -32'sd1, 0, 0, 0, 32'sd1};
      send_matrix(m);
      // extreme entries with a nonzero determinant
      m = '{32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0,
            0, 0, 32'hffff_ffff};
      send_matrix(m);
      // general full matrix with mixed signs
      m = '{32'sh2_0000, -32'sh1_0000, 32'sh0_8000, 32'sh0_4000, 32'sh3_0000,
            -32'sh2_8000, 32'sh1_0000, 32'sh0_c000, -32'sh1_0000};
      send_matrix(m);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_entry_value = '0;
      rsp_stall = 1'b0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 29;
      recv_stall_pct = 83;
      directed_part();
      for (int n = 0; n < 25; n++) begin
         if (n == 9) begin
            send_idle_pct = 83;
            recv_stall_pct = 29;
         end else if (n == 18) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         send_random_matrix();
      end
      req_valid <= 1'b0;

      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
